### design/vertex_dedup_table_core_assert.svh
// assertion macros for the vertex dedup table core
`ifndef VERTEX_DEDUP_TABLE_CORE_ASSERT_SVH
`define VERTEX_DEDUP_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define VDT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("vdt assertion failed");
`define VDT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("vdt assertion failed");
`else
`define VDT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define VDT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### design/vdt_pkg.sv
// shared widths and defaults for the vertex dedup table
package vdt_pkg;
  localparam int COORD_W         = 32;
  localparam int POINT_W         = 3 * COORD_W;
  localparam int OUT_IDX_W       = 8;
  localparam int TABLE_DEPTH_DEF = 256;
endpackage

### design/vdt_ram.sv
// generic single-port-write, single-port-read ram with registered read
module vdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

### design/vertex_dedup_table_core.sv
// find-or-insert table of 3d points, top level
//
// channel  direction  handshake                  payload
// request  in         start && !busy             in_x_coord, in_y_coord, in_z_coord
// result   out        out_valid (one cycle)      out_point_index, out_was_added, out_status
//
// a request against an empty table is stored in the cycle it is taken; otherwise
// the stored points are compared in order until a hit or the last entry,
// one entry per cycle, set by the single read port of the point ram
// the result shows in the cycle after the request finishes; the next request
// may be taken in that same cycle
// reset (rst_n low, synchronous) empties the table; no clearing pass
module vertex_dedup_table_core #(
  parameter int TABLE_DEPTH = vdt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [vdt_pkg::COORD_W-1:0]    in_x_coord,
  input  logic [vdt_pkg::COORD_W-1:0]    in_y_coord,
  input  logic [vdt_pkg::COORD_W-1:0]    in_z_coord,
  output logic                           out_valid,
  output logic [vdt_pkg::OUT_IDX_W-1:0]  out_point_index,
  output logic                           out_was_added,
  output logic                           out_status
);
  import vdt_pkg::*;

`include "vertex_dedup_table_core_assert.svh"

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [POINT_W-1:0]   pt_r, pt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_IDX_W-1:0] out_point_index_r, out_point_index_nxt;
  logic                 out_was_added_r, out_was_added_nxt;
  logic                 out_status_r, out_status_nxt;

  logic                 accept;
  logic                 hit;
  logic                 last;
  logic                 full;
  logic [CNT_W-1:0]     next_idx;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [POINT_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [POINT_W-1:0]   ram_rdata;

  vdt_ram #(
    .WIDTH (POINT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_point_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign hit      = (ram_rdata == pt_r);
  assign next_idx = CNT_W'(cmp_idx_r) + CNT_W'(1);
  assign last     = (next_idx == cnt_r);
  assign full     = (cnt_r == CNT_W'(TABLE_DEPTH));

  always_comb begin
    state_nxt           = state_r;
    cnt_nxt             = cnt_r;
    cmp_idx_nxt         = cmp_idx_r;
    pt_nxt              = pt_r;
    out_valid_nxt       = 1'b0;
    out_point_index_nxt = out_point_index_r;
    out_was_added_nxt   = out_was_added_r;
    out_status_nxt      = out_status_r;
    ram_we              = 1'b0;
    ram_waddr           = cnt_r[IDX_W-1:0];
    ram_wdata           = pt_r;
    ram_raddr           = '0;
    case (state_r)
      ST_IDLE: begin
        ram_raddr = '0;
        if (accept) begin
          pt_nxt = {in_x_coord, in_y_coord, in_z_coord};
          if (cnt_r == '0) begin
            // empty table: store at entry zero at once
            ram_we              = 1'b1;
            ram_waddr           = '0;
            ram_wdata           = {in_x_coord, in_y_coord, in_z_coord};
            cnt_nxt             = CNT_W'(1);
            out_valid_nxt       = 1'b1;
            out_point_index_nxt = '0;
            out_was_added_nxt   = 1'b1;
            out_status_nxt      = 1'b0;
          end else begin
            cmp_idx_nxt = '0;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ram_raddr = next_idx[IDX_W-1:0];
        if (hit) begin
          out_valid_nxt       = 1'b1;
          out_point_index_nxt = OUT_IDX_W'(cmp_idx_r);
          out_was_added_nxt   = 1'b0;
          out_status_nxt      = 1'b0;
          state_nxt           = ST_IDLE;
        end else if (last) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (full) begin
            out_point_index_nxt = '0;
            out_was_added_nxt   = 1'b0;
            out_status_nxt      = 1'b1;
          end else begin
            ram_we              = 1'b1;
            cnt_nxt             = cnt_r + CNT_W'(1);
            out_point_index_nxt = OUT_IDX_W'(cnt_r);
            out_was_added_nxt   = 1'b1;
            out_status_nxt      = 1'b0;
          end
        end else begin
          cmp_idx_nxt = next_idx[IDX_W-1:0];
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r         <= cmp_idx_nxt;
    pt_r              <= pt_nxt;
    out_point_index_r <= out_point_index_nxt;
    out_was_added_r   <= out_was_added_nxt;
    out_status_r      <= out_status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_point_index = out_point_index_r;
  assign out_was_added   = out_was_added_r;
  assign out_status      = out_status_r;

  `VDT_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(TABLE_DEPTH))
  `VDT_ASSERT_IMP(a_scan_nonempty, clk, rst_n, state_r == ST_SCAN, cnt_r != '0)
  `VDT_ASSERT_NXT(a_empty_insert, clk, rst_n, accept && cnt_r == '0,
                  out_valid_r && out_was_added_r && out_point_index_r == '0)
  `VDT_ASSERT_IMP(a_full_status, clk, rst_n, out_valid_r && out_status_r,
                  full && !out_was_added_r)
  `VDT_ASSERT_IMP(a_added_grows, clk, rst_n, out_valid_r && out_was_added_r,
                  cnt_r == $past(cnt_r) + CNT_W'(1))
endmodule
